>>> sv/rtte_pkg.sv
// Shared types and constants for the retransmission-timeout estimator.
package rtte_pkg;

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_BACKOFF = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_RESTART = 2'd3
    } req_type_t;

    localparam int SAMPLE_W  = 14;
    localparam int SRTT_W    = 18;
    localparam int RTTVAR_W  = 18;
    localparam int DEV_W     = 16;
    localparam int TIMEOUT_W = 23;
    localparam int WHOLE_W   = 15;
    localparam int BLOG_W    = 3;
    localparam int FACTOR_W  = 7;

    localparam logic [BLOG_W-1:0]    BACKOFF_LOG_MAX  = 3'd6;
    localparam logic [BLOG_W-1:0]    BACKOFF_LOG_DEEP = 3'd3;
    localparam logic [DEV_W-1:0]     DEV_RESET        = 16'd30;
    localparam logic [TIMEOUT_W-1:0] MAX_TIMEOUT_RST  = 23'd20000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN      = 23'd2;

    localparam logic REG_IDX_DEV = 1'b0;
    localparam logic REG_IDX_MAX = 1'b1;

    typedef struct packed {
        logic [WHOLE_W-1:0]  srtt_whole;
        logic [RTTVAR_W-1:0] rttvar;
        logic [BLOG_W-1:0]   backoff_log;
    } est_state_t;

endpackage

>>> sv/rtt_estimator_rto_timer.sv
// Top level of the retransmission-timeout estimator with its register port and stream pipeline.
// The block takes one request beat per clock unless the output stalls with the snapshot full,
// and answers every beat with exactly one result beat via the snapshot and output registers.
// The rate is set by the estimator state update, a loop of adds and compares on the smoothed
// round trip, the deviation and the backoff exponent. A snapshot register holds the new
// state of each beat and the timeout product, clamp and floor are formed between it and
// the output register, so one further beat can be accepted while a result waits to be taken.
// Registers: initial deviation at byte address 0, maximum timeout at byte address 4.
module rtt_estimator_rto_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] rtt_sample, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [22:0] timeout_ticks, [23] timeout_saturated,
                                   // [30:24] backoff_factor, [45:31] smoothed_rtt, [47:46] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [rtte_pkg::DEV_W-1:0]     init_dev_reg;
    logic [rtte_pkg::TIMEOUT_W-1:0] max_timeout_reg;
    logic                           cfg_wr;

    logic                           accept;
    logic                           move;
    rtte_pkg::est_state_t           state_next;
    rtte_pkg::est_state_t           snap_reg;
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;

    logic [18:0]                    base;
    logic [24:0]                    product;
    logic                           sat;
    logic [rtte_pkg::TIMEOUT_W-1:0] clamped;
    logic [rtte_pkg::TIMEOUT_W-1:0] timeout;

    logic [rtte_pkg::TIMEOUT_W-1:0] m_timeout_reg;
    logic                           m_sat_reg;
    logic [rtte_pkg::FACTOR_W-1:0]  m_factor_reg;
    logic [rtte_pkg::WHOLE_W-1:0]   m_srtt_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_dev_reg    <= rtte_pkg::DEV_RESET;
            max_timeout_reg <= rtte_pkg::MAX_TIMEOUT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                rtte_pkg::REG_IDX_DEV: init_dev_reg    <= pwdata[15:0];
                rtte_pkg::REG_IDX_MAX: max_timeout_reg <= pwdata[22:0];
                default:               init_dev_reg    <= init_dev_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rtte_pkg::REG_IDX_DEV: prdata = {16'd0, init_dev_reg};
            rtte_pkg::REG_IDX_MAX: prdata = {9'd0, max_timeout_reg};
            default:               prdata = '0;
        endcase
    end

    assign move     = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    rtte_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd_en     (accept),
        .req        (rtte_pkg::req_type_t'(s_tuser)),
        .rtt_sample (s_tdata[13:0]),
        .init_dev   (init_dev_reg),
        .state_next (state_next)
    );

    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (move) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            snap_reg <= state_next;
        end
    end

    always_comb begin
        base    = {4'd0, snap_reg.srtt_whole} + {1'b0, snap_reg.rttvar};
        product = {6'd0, base} << snap_reg.backoff_log;
        sat     = product > {2'b00, max_timeout_reg};
        clamped = sat ? max_timeout_reg : product[22:0];
        timeout = (clamped < rtte_pkg::TIMEOUT_MIN) ? rtte_pkg::TIMEOUT_MIN : clamped;
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_timeout_reg <= timeout;
            m_sat_reg     <= sat;
            m_factor_reg  <= 7'd1 << snap_reg.backoff_log;
            m_srtt_reg    <= snap_reg.srtt_whole;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_srtt_reg, m_factor_reg, m_sat_reg, m_timeout_reg};

endmodule

>>> sv/rtte_state.sv
// Estimator state registers and their update for one request.
module rtte_state (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                upd_en,
    input  rtte_pkg::req_type_t                 req,
    input  logic [rtte_pkg::SAMPLE_W-1:0]       rtt_sample,
    input  logic [rtte_pkg::DEV_W-1:0]          init_dev,
    output rtte_pkg::est_state_t                state_next
);

    logic [rtte_pkg::SRTT_W-1:0]   srtt_reg;
    logic [rtte_pkg::SRTT_W-1:0]   srtt_next;
    logic [rtte_pkg::RTTVAR_W-1:0] rttvar_reg;
    logic [rtte_pkg::RTTVAR_W-1:0] rttvar_next;
    logic [rtte_pkg::BLOG_W-1:0]   blog_reg;
    logic [rtte_pkg::BLOG_W-1:0]   blog_next;

    logic [rtte_pkg::SAMPLE_W-1:0] rtt;
    logic signed [16:0]            diff;
    logic [15:0]                   diff_abs;
    logic signed [16:0]            var_delta;
    logic signed [19:0]            srtt_sum;
    logic signed [19:0]            var_sum;

    function automatic logic [17:0] sat18(input logic signed [19:0] v);
        logic [17:0] r;
        if (v < 20'sd1) begin
            r = 18'd1;
        end else if (v > 20'sd262143) begin
            r = 18'h3FFFF;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    always_comb begin
        rtt       = (rtt_sample == '0) ? 14'd1 : rtt_sample;
        diff      = $signed({3'b000, rtt}) - $signed({2'b00, srtt_reg[17:3]});
        diff_abs  = diff[16] ? 16'(-diff) : diff[15:0];
        var_delta = $signed({1'b0, diff_abs}) - $signed({1'b0, rttvar_reg[17:2]});
        srtt_sum  = $signed({2'b00, srtt_reg}) + $signed({{3{diff[16]}}, diff});
        var_sum   = $signed({2'b00, rttvar_reg}) + $signed({{3{var_delta[16]}}, var_delta});
    end

    always_comb begin
        srtt_next   = srtt_reg;
        rttvar_next = rttvar_reg;
        blog_next   = blog_reg;
        case (req)
            rtte_pkg::REQ_SAMPLE: begin
                if (srtt_reg == '0) begin
                    srtt_next   = {1'b0, rtt, 3'b000};
                    rttvar_next = {3'b000, rtt, 1'b0};
                end else begin
                    srtt_next   = sat18(srtt_sum);
                    rttvar_next = sat18(var_sum);
                end
            end
            rtte_pkg::REQ_BACKOFF: begin
                if (blog_reg < rtte_pkg::BACKOFF_LOG_MAX) begin
                    blog_next = blog_reg + 3'd1;
                end
                if (blog_next > rtte_pkg::BACKOFF_LOG_DEEP) begin
                    srtt_next = '0;
                end
            end
            rtte_pkg::REQ_CLEAR: begin
                blog_next = '0;
            end
            rtte_pkg::REQ_RESTART: begin
                srtt_next   = '0;
                rttvar_next = {2'b00, init_dev};
                blog_next   = '0;
            end
            default: begin
                blog_next = blog_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srtt_reg   <= '0;
            rttvar_reg <= {2'b00, rtte_pkg::DEV_RESET};
            blog_reg   <= '0;
        end else if (upd_en) begin
            srtt_reg   <= srtt_next;
            rttvar_reg <= rttvar_next;
            blog_reg   <= blog_next;
        end
    end

    assign state_next.srtt_whole  = srtt_next[17:3];
    assign state_next.rttvar      = rttvar_next;
    assign state_next.backoff_log = blog_next;

endmodule

>>> sv/rtte_checker.sv
// Port-level checks for the retransmission-timeout estimator and their binding.
module rtte_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result beat changed while stalled.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result beat offered straight after reset.");

    a_factor_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[30:24]))
        else $error("Backoff factor is not a power of two.");

    a_timeout_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[22:0] >= 23'd2)
        else $error("Timeout below the two-tick floor.");

endmodule

bind rtt_estimator_rto_timer rtte_checker u_rtte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/rtt_estimator_rto_timer_test.sv
// Self-checking stream testbench for the retransmission-timeout estimator with its register port.
`timescale 1ns / 1ps

module rtt_estimator_rto_timer_test;

    localparam int         QUIET_LIMIT = 2000;
    localparam int         MAX_PRINTS  = 40;
    localparam logic [2:0] ADDR_DEV    = {rtte_pkg::REG_IDX_DEV, 2'b00};
    localparam logic [2:0] ADDR_MAX    = {rtte_pkg::REG_IDX_MAX, 2'b00};
    localparam int         SAT_BIT     = rtte_pkg::TIMEOUT_W;
    localparam int         FACTOR_LO   = rtte_pkg::TIMEOUT_W + 1;
    localparam int         FACTOR_HI   = rtte_pkg::TIMEOUT_W + rtte_pkg::FACTOR_W;
    localparam int         WHOLE_LO    = FACTOR_HI + 1;
    localparam int         WHOLE_HI    = FACTOR_HI + rtte_pkg::WHOLE_W;

    typedef struct {
        rtte_pkg::req_type_t           kind;
        logic [rtte_pkg::SAMPLE_W-1:0] rtt;
    } rto_req_t;

    typedef struct packed {
        logic [rtte_pkg::WHOLE_W-1:0]   whole;
        logic [rtte_pkg::FACTOR_W-1:0]  factor;
        logic                           sat;
        logic [rtte_pkg::TIMEOUT_W-1:0] ticks;
    } rto_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [rtte_pkg::DEV_W-1:0]     cfg_dev;
    logic [rtte_pkg::TIMEOUT_W-1:0] cfg_max;
    logic [rtte_pkg::SRTT_W-1:0]    est_srtt;
    logic [rtte_pkg::RTTVAR_W-1:0]  est_var;
    logic [rtte_pkg::FACTOR_W-1:0]  est_backoff;

    rto_req_t    pending_reqs[$];
    rto_result_t rto_expected[$];
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    rtt_estimator_rto_timer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [rtte_pkg::SRTT_W-1:0] floor_sat_state(longint v);
        if (v < 1) return {{(rtte_pkg::SRTT_W-1){1'b0}}, 1'b1};
        if (v > (longint'(1) << rtte_pkg::SRTT_W) - 1) return '1;
        return v[rtte_pkg::SRTT_W-1:0];
    endfunction

    function automatic void restart_estimate();
        est_srtt    = '0;
        est_var     = {{(rtte_pkg::RTTVAR_W-rtte_pkg::DEV_W){1'b0}}, cfg_dev};
        est_backoff = {{(rtte_pkg::FACTOR_W-1){1'b0}}, 1'b1};
    endfunction

    function automatic rto_result_t predict_rto(rto_req_t req);
        longint      rtt, d, cur_srtt, cur_var, factor, prod, seed;
        rto_result_t r;
        rtt      = longint'(req.rtt);
        cur_srtt = longint'(est_srtt);
        cur_var  = longint'(est_var);
        if (rtt < 1) rtt = 1;
        case (req.kind)
            rtte_pkg::REQ_SAMPLE: begin
                if (cur_srtt == 0) begin
                    seed     = rtt * 8;
                    est_srtt = seed[rtte_pkg::SRTT_W-1:0];
                    seed     = rtt * 2;
                    est_var  = seed[rtte_pkg::RTTVAR_W-1:0];
                end else begin
                    d        = rtt - cur_srtt / 8;
                    est_srtt = floor_sat_state(cur_srtt + d);
                    if (d < 0) d = -d;
                    est_var  = floor_sat_state(cur_var + d - cur_var / 4);
                end
            end
            rtte_pkg::REQ_BACKOFF: begin
                if (est_backoff < 7'd64) est_backoff = est_backoff << 1;
                if (est_backoff > 7'd8) est_srtt = '0;
            end
            rtte_pkg::REQ_CLEAR: est_backoff = {{(rtte_pkg::FACTOR_W-1){1'b0}}, 1'b1};
            default: restart_estimate();
        endcase
        cur_srtt = longint'(est_srtt);
        cur_var  = longint'(est_var);
        factor   = longint'(est_backoff);
        prod     = (cur_srtt / 8 + cur_var) * factor;
        r.sat    = (prod > longint'(cfg_max));
        if (r.sat) prod = longint'(cfg_max);
        if (prod < 2) prod = 2;
        r.ticks  = prod[rtte_pkg::TIMEOUT_W-1:0];
        r.factor = est_backoff;
        r.whole  = est_srtt[rtte_pkg::SRTT_W-1:3];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // Driver: predicts each request beat as it is accepted, then offers the next one.
    always @(posedge aclk) begin : request_driver
        rto_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                req.kind = rtte_pkg::req_type_t'(s_tuser);
                req.rtt  = s_tdata[rtte_pkg::SAMPLE_W-1:0];
                rto_expected.push_back(predict_rto(req));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req.kind;
                    s_tdata  <= {2'b00, req.rtt};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        rto_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (rto_expected.size() == 0) begin
                    report_mismatch("result beat arrived with no prediction pending");
                end else begin
                    want = rto_expected.pop_front();
                    if (m_tdata[rtte_pkg::TIMEOUT_W-1:0] !== want.ticks)
                        report_mismatch($sformatf("timeout_ticks %0d, expected %0d",
                            m_tdata[rtte_pkg::TIMEOUT_W-1:0], want.ticks));
                    if (m_tdata[SAT_BIT] !== want.sat)
                        report_mismatch($sformatf("timeout_saturated %0b, expected %0b",
                            m_tdata[SAT_BIT], want.sat));
                    if (m_tdata[FACTOR_HI:FACTOR_LO] !== want.factor)
                        report_mismatch($sformatf("backoff_factor %0d, expected %0d",
                            m_tdata[FACTOR_HI:FACTOR_LO], want.factor));
                    if (m_tdata[WHOLE_HI:WHOLE_LO] !== want.whole)
                        report_mismatch($sformatf("smoothed_rtt %0d, expected %0d",
                            m_tdata[WHOLE_HI:WHOLE_LO], want.whole));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || rto_expected.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DEV) cfg_dev = value[rtte_pkg::DEV_W-1:0];
        else if (addr == ADDR_MAX) cfg_max = value[rtte_pkg::TIMEOUT_W-1:0];
    endtask

    task automatic queue_req(input rtte_pkg::req_type_t kind, input int rtt);
        rto_req_t req;
        req.kind = kind;
        req.rtt  = rtt[rtte_pkg::SAMPLE_W-1:0];
        pending_reqs.push_back(req);
    endtask

    function automatic int pick_base();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return $urandom_range(40);
        if (sel < 85) return $urandom_range(2000);
        return $urandom_range(16383);
    endfunction

    // Mostly jittered samples about a drifting mean, plus backoff bursts, clears and restarts.
    task automatic queue_random(input int count);
        int base, jit, rtt, pick, burst, queued;
        base   = pick_base();
        queued = 0;
        while (queued < count) begin
            pick = $urandom_range(99);
            if (pick < 5) base = pick_base();
            if (pick < 62) begin
                if ($urandom_range(9) == 0) begin
                    rtt = $urandom_range(16383);
                end else begin
                    jit = $urandom_range(base / 2 + 2);
                    rtt = base + jit - (base / 4 + 1);
                    if (rtt < 0) rtt = 0;
                    if (rtt > 16383) rtt = 16383;
                end
                queue_req(rtte_pkg::REQ_SAMPLE, rtt);
                queued++;
            end else if (pick < 77) begin
                burst = $urandom_range(7, 1);
                repeat (burst) queue_req(rtte_pkg::REQ_BACKOFF, $urandom_range(16383));
                queued += burst;
            end else if (pick < 90) begin
                queue_req(rtte_pkg::REQ_CLEAR, $urandom_range(16383));
                queued++;
            end else begin
                queue_req(rtte_pkg::REQ_RESTART, $urandom_range(16383));
                queued++;
            end
        end
    endtask

    initial begin : stimulus
        cfg_dev = rtte_pkg::DEV_RESET;
        cfg_max = rtte_pkg::MAX_TIMEOUT_RST;
        restart_estimate();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_req(rtte_pkg::REQ_SAMPLE, 0);
        queue_req(rtte_pkg::REQ_SAMPLE, 16383);
        queue_req(rtte_pkg::REQ_CLEAR, 16383);
        repeat (7) queue_req(rtte_pkg::REQ_BACKOFF, 0);
        queue_req(rtte_pkg::REQ_SAMPLE, 16383);
        queue_req(rtte_pkg::REQ_RESTART, 0);
        queue_req(rtte_pkg::REQ_SAMPLE, 16383);
        queue_req(rtte_pkg::REQ_RESTART, 16383);
        wait_drained();

        write_reg(ADDR_DEV, 0);
        write_reg(ADDR_MAX, 8388607);
        queue_req(rtte_pkg::REQ_RESTART, 0);
        queue_req(rtte_pkg::REQ_BACKOFF, 0);
        queue_req(rtte_pkg::REQ_SAMPLE, 5);
        wait_drained();

        write_reg(ADDR_DEV, 65535);
        write_reg(ADDR_MAX, 2);
        queue_req(rtte_pkg::REQ_RESTART, 0);
        queue_req(rtte_pkg::REQ_SAMPLE, 16383);
        wait_drained();

        write_reg(ADDR_MAX, 8388607);
        queue_req(rtte_pkg::REQ_RESTART, 0);
        repeat (6) queue_req(rtte_pkg::REQ_BACKOFF, 16383);
        wait_drained();

        send_idle_pct  = 30;
        recv_stall_pct = 78;
        write_reg(ADDR_DEV, $urandom_range(65535));
        write_reg(ADDR_MAX, $urandom_range(200000, 2));
        queue_random(300);
        wait_drained();
        queue_random(300);
        wait_drained();

        send_idle_pct  = 78;
        recv_stall_pct = 30;
        write_reg(ADDR_DEV, 65535);
        write_reg(ADDR_MAX, 8388607);
        queue_random(300);
        wait_drained();
        queue_random(300);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(ADDR_DEV, 0);
        write_reg(ADDR_MAX, $urandom_range(5000, 2));
        queue_random(300);
        wait_drained();
        queue_random(300);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
